// ===== hw/rtl/tsq_pkg.sv =====
package tsq_pkg;

  // schedule table geometry
  localparam int MAX_ENTRIES = 1024;
  localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int MAX_FRAMES  = 4096;

  // field widths
  localparam int FRAME_W    = 12;
  localparam int DUR_W      = 20;
  localparam int SLOT_W     = 10;
  localparam int POS_W      = 12;
  localparam int FCOUNT_W   = 13;
  localparam int SLEN_W     = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [DUR_W-1:0] DURATION_LIMIT = 20'd1000000;

  // item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCHEDULE_LENGTH = 1'd1;

  // one schedule entry as stored in the table
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [DUR_W-1:0]   duration;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result beat
  typedef struct packed {
    logic               frame_changed;
    logic [FRAME_W-1:0] new_frame;
    logic               load_rejected;
  } result_t;

  // frame count with zero taken as one and a ceiling at the strip maximum
  function automatic logic [FCOUNT_W-1:0] active_frames(input logic [FCOUNT_W-1:0] fc);
    logic [FCOUNT_W-1:0] res;
    if (fc == '0) begin
      res = FCOUNT_W'(1);
    end else if (fc > FCOUNT_W'(MAX_FRAMES)) begin
      res = FCOUNT_W'(MAX_FRAMES);
    end else begin
      res = fc;
    end
    return res;
  endfunction

  // schedule length with a ceiling at the table depth
  function automatic logic [SLEN_W-1:0] active_length(input logic [SLEN_W-1:0] sl);
    logic [SLEN_W-1:0] res;
    if (sl > SLEN_W'(MAX_ENTRIES)) begin
      res = SLEN_W'(MAX_ENTRIES);
    end else begin
      res = sl;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/tsq_ram.sv =====
module tsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports, old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== hw/rtl/timed_frame_sequencer_top.sv =====
// channel  | direction | handshake        | beat contents
// ---------+-----------+------------------+---------------------------------------------
// in       | input     | in_valid/in_stall   | opcode, entry_slot, entry_frame, entry_duration
// out      | output    | out_valid/out_stall | frame_changed, new_frame, load_rejected
// cfg      | input     | cfg_write           | cfg_index, cfg_data
//
// One item per cycle while in_stall is low: each beat is settled in the cycle it is taken, using
// the current and following schedule entries, which the two read ports fetch the cycle before.
// Results pass through a two-entry output buffer, so input takes a beat while one result waits;
// in_stall rises only when both buffer entries hold results.
// Reset (rst, synchronous) clears position, tick count, schedule length and the buffer and
// sets the frame count to one; the schedule table is not cleared and entries are undefined until loaded.
module timed_frame_sequencer_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             opcode,
  input  logic [tsq_pkg::SLOT_W-1:0]       entry_slot,
  input  logic [tsq_pkg::FRAME_W-1:0]      entry_frame,
  input  logic [tsq_pkg::DUR_W-1:0]        entry_duration,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             frame_changed,
  output logic [tsq_pkg::FRAME_W-1:0]      new_frame,
  output logic                             load_rejected,
  input  logic                             cfg_write,
  input  logic [tsq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import tsq_pkg::*;

  // configuration and position state
  logic [FCOUNT_W-1:0] frame_count, frame_count_next;
  logic [SLEN_W-1:0]   schedule_length, schedule_length_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [ENTRY_AW-1:0] pos1, pos1_next;
  logic [DUR_W-1:0]    tick_count, tick_count_next;

  // table access
  logic                we;
  entry_t              wentry, wentry_q;
  entry_t              ram_q0, ram_q1, cur, nxt;
  logic                fwd0, fwd1;
  logic [ENTRY_AW-1:0] raddr0, raddr1;

  // output buffer
  result_t res, head, skid;
  logic    head_valid, skid_valid;
  logic    push, pop;

  // derived values
  logic [FCOUNT_W-1:0] frames_eff;
  logic [SLEN_W-1:0]   len_eff, len_next_eff;
  logic [DUR_W-1:0]    tick_inc;
  logic                adv;
  logic [SLEN_W-1:0]   pos1_inc;
  logic [ENTRY_AW-1:0] pos1_wrap;
  logic [POS_W-1:0]    cyc_cur, cyc_new;
  logic [FCOUNT_W-1:0] cyc_inc;
  logic                reject;

  assign frames_eff = active_frames(frame_count);
  assign len_eff    = active_length(schedule_length);

  assign push     = in_valid && !in_stall;
  assign pop      = head_valid && !out_stall;
  assign in_stall = skid_valid;

  // table read data with forwarding of last cycle's load
  assign cur = fwd0 ? wentry_q : ram_q0;
  assign nxt = fwd1 ? wentry_q : ram_q1;

  // schedule mode step
  assign tick_inc  = tick_count + DUR_W'(1);
  assign adv       = tick_inc >= cur.duration;
  assign pos1_inc  = SLEN_W'(pos1) + SLEN_W'(1);
  assign pos1_wrap = (pos1_inc >= len_eff) ? '0 : pos1_inc[ENTRY_AW-1:0];

  // plain cycling step
  assign cyc_cur = (FCOUNT_W'(pos) >= frames_eff) ? '0 : pos;
  assign cyc_inc = FCOUNT_W'(cyc_cur) + FCOUNT_W'(1);
  assign cyc_new = (cyc_inc >= frames_eff) ? '0 : cyc_inc[POS_W-1:0];

  // load check
  assign reject = (FCOUNT_W'(entry_frame) >= frames_eff) || (entry_duration == '0)
                  || (entry_duration > DURATION_LIMIT);

  assign wentry.frame    = entry_frame;
  assign wentry.duration = entry_duration;

  // next state and result of the beat
  always_comb begin
    frame_count_next     = frame_count;
    schedule_length_next = schedule_length;
    pos_next             = pos;
    pos1_next            = pos1;
    tick_count_next      = tick_count;
    we                   = 1'b0;
    res                  = '0;
    len_next_eff         = len_eff;
    if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_COUNT: begin
          frame_count_next = cfg_data[FCOUNT_W-1:0];
        end
        REG_SCHEDULE_LENGTH: begin
          schedule_length_next = cfg_data[SLEN_W-1:0];
        end
        default: begin
        end
      endcase
      len_next_eff    = active_length(schedule_length_next);
      pos_next        = '0;
      tick_count_next = '0;
      pos1_next       = (len_next_eff > SLEN_W'(1)) ? ENTRY_AW'(1) : '0;
    end else if (push) begin
      if (opcode == OP_LOAD) begin
        res.load_rejected = reject;
        we                = !reject;
      end else if (len_eff != '0) begin
        if (adv) begin
          tick_count_next = '0;
          pos_next        = POS_W'(pos1);
          pos1_next       = pos1_wrap;
          if (nxt.frame != cur.frame && FCOUNT_W'(nxt.frame) < frames_eff) begin
            res.frame_changed = 1'b1;
            res.new_frame     = nxt.frame;
          end
        end else begin
          tick_count_next = tick_inc;
        end
      end else begin
        pos_next = cyc_new;
        if (cyc_new != cyc_cur) begin
          res.frame_changed = 1'b1;
          res.new_frame     = cyc_new[FRAME_W-1:0];
        end
      end
    end
  end

  // prefetch the entries of the next position and the one after it
  assign raddr0 = pos_next[ENTRY_AW-1:0];
  assign raddr1 = pos1_next;

  tsq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk    (clk),
    .we     (we),
    .waddr  (entry_slot[ENTRY_AW-1:0]),
    .wdata  (wentry),
    .raddr0 (raddr0),
    .rdata0 (ram_q0),
    .raddr1 (raddr1),
    .rdata1 (ram_q1)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count     <= FCOUNT_W'(1);
      schedule_length <= '0;
      pos             <= '0;
      pos1            <= '0;
      tick_count      <= '0;
      fwd0            <= 1'b0;
      fwd1            <= 1'b0;
    end else begin
      frame_count     <= frame_count_next;
      schedule_length <= schedule_length_next;
      pos             <= pos_next;
      pos1            <= pos1_next;
      tick_count      <= tick_count_next;
      fwd0            <= we && (entry_slot[ENTRY_AW-1:0] == raddr0);
      fwd1            <= we && (entry_slot[ENTRY_AW-1:0] == raddr1);
    end
  end

  // load data kept for forwarding
  always_ff @(posedge clk) begin
    wentry_q <= wentry;
  end

  // two-entry output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!head_valid || pop) begin
        head_valid <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      head <= skid_valid ? skid : res;
    end else if (push) begin
      skid <= res;
    end
  end

  assign out_valid     = head_valid;
  assign frame_changed = head.frame_changed;
  assign new_frame     = head.new_frame;
  assign load_rejected = head.load_rejected;

endmodule

// ===== hw/rtl/tsq_checker.sv =====
module tsq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        frame_changed,
  input logic [tsq_pkg::FRAME_W-1:0] new_frame,
  input logic                        load_rejected
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(frame_changed) && $stable(new_frame)
                               && $stable(load_rejected))
    else $error("result payload changed while stalled");

  // a beat is either a tick report or a load report, never both
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_changed && load_rejected))
    else $error("frame change and load reject in one beat");

  // frame field is zero unless a change is reported
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_changed |-> new_frame == '0)
    else $error("frame reported without a change");

  // buffer is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind timed_frame_sequencer_top tsq_checker u_tsq_checker (.*);

// ===== tb/timed_frame_sequencer_top_test.sv =====
module timed_frame_sequencer_top_test;
  import tsq_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 4;

  // schedule tracker: own copy of table, position and registers, plus the
  // results that accepted beats still owe
  class frame_scoreboard;
    logic [FRAME_W-1:0]  slot_frame [MAX_ENTRIES];
    logic [DUR_W-1:0]    slot_dur [MAX_ENTRIES];
    int                  pos;
    logic [DUR_W-1:0]    ticks;
    logic [FCOUNT_W-1:0] frame_count;
    logic [SLEN_W-1:0]   sched_len;
    result_t             expected_frames[$];
    int                  errors;

    function new();
      pos = 0;
      ticks = '0;
      frame_count = FCOUNT_W'(1);
      sched_len = '0;
      errors = 0;
    endfunction

    // zero acts as one frame, the strip is capped at its maximum
    function int frames_in_use();
      if (frame_count == '0) return 1;
      if (int'(frame_count) > MAX_FRAMES) return MAX_FRAMES;
      return int'(frame_count);
    endfunction

    function int length_in_use();
      if (int'(sched_len) > MAX_ENTRIES) return MAX_ENTRIES;
      return int'(sched_len);
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FRAME_COUNT) frame_count = data[FCOUNT_W-1:0];
      else sched_len = data[SLEN_W-1:0];
      pos = 0;
      ticks = '0;
    endfunction

    function void note_item(logic op, logic [SLOT_W-1:0] slot, logic [FRAME_W-1:0] frm,
                            logic [DUR_W-1:0] dur);
      result_t r;
      int len, cnt, old_frame, next_frame, old_pos;
      r = '0;
      if (op == OP_LOAD) begin
        // refused loads leave the table alone
        if (int'(slot) >= MAX_ENTRIES || int'(frm) >= frames_in_use() ||
            int'(frm) >= MAX_FRAMES || dur == '0 || dur > DURATION_LIMIT) begin
          r.load_rejected = 1'b1;
        end else begin
          slot_frame[slot] = frm;
          slot_dur[slot]   = dur;
        end
      end else begin
        len = length_in_use();
        if (len != 0) begin
          // schedule mode: count ticks, move on when the entry has run out
          if (pos >= len) pos = 0;
          ticks = ticks + 1'b1;
          if (ticks >= slot_dur[pos]) begin
            old_frame = int'(slot_frame[pos]);
            pos = (pos + 1 >= len) ? 0 : pos + 1;
            ticks = '0;
            next_frame = int'(slot_frame[pos]);
            if (next_frame != old_frame && next_frame < frames_in_use()) begin
              r.frame_changed = 1'b1;
              r.new_frame = FRAME_W'(next_frame);
            end
          end
        end else begin
          // plain cycling through the strip
          cnt = frames_in_use();
          if (pos >= cnt) pos = 0;
          old_pos = pos;
          pos = (pos + 1 >= cnt) ? 0 : pos + 1;
          if (pos != old_pos) begin
            r.frame_changed = 1'b1;
            r.new_frame = FRAME_W'(pos);
          end
        end
      end
      expected_frames.push_back(r);
    endfunction

    function void check_result(logic fc, logic [FRAME_W-1:0] nf, logic lr);
      result_t exp_r;
      if (expected_frames.size() == 0) begin
        $error("result beat with nothing pending: %s %0d %s %0d %s %0d",
               "frame_changed", fc, "new_frame", nf, "load_rejected", lr);
        errors++;
        return;
      end
      exp_r = expected_frames.pop_front();
      if (fc !== exp_r.frame_changed) begin
        $error("frame_changed: expected %0d, actual %0d", exp_r.frame_changed, fc);
        errors++;
      end
      if (nf !== exp_r.new_frame) begin
        $error("new_frame: expected %0d, actual %0d", exp_r.new_frame, nf);
        errors++;
      end
      if (lr !== exp_r.load_rejected) begin
        $error("load_rejected: expected %0d, actual %0d", exp_r.load_rejected, lr);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  opcode;
  logic [SLOT_W-1:0]     entry_slot;
  logic [FRAME_W-1:0]    entry_frame;
  logic [DUR_W-1:0]      entry_duration;
  logic                  out_valid;
  logic                  out_stall;
  logic                  frame_changed;
  logic [FRAME_W-1:0]    new_frame;
  logic                  load_rejected;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  frame_scoreboard sb = new();
  bit calm;
  bit squeeze;
  int items_sent;
  int quiet_cycles;

  timed_frame_sequencer_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .entry_slot     (entry_slot),
    .entry_frame    (entry_frame),
    .entry_duration (entry_duration),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_changed  (frame_changed),
    .new_frame      (new_frame),
    .load_rejected  (load_rejected),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // offer one input beat, with random idle cycles ahead of it
  task automatic send_item(logic op, logic [SLOT_W-1:0] slot, logic [FRAME_W-1:0] frm,
                           logic [DUR_W-1:0] dur);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    entry_slot     <= slot;
    entry_frame    <= frm;
    entry_duration <= dur;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, slot, frm, dur);
    items_sent++;
  endtask

  // register write once every pending result is out
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // receiver stall: random idling, one long hold-off on request
  initial begin : rx_drive
    int hold;
    bit held;
    out_stall = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        for (hold = 0; hold < HOLD_CYCLES; hold++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 7);
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      sb.check_result(frame_changed, new_frame, load_rejected);
    end
  end

  // watchdog on cycles with no beat taken anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main
    int phase, n, k, r, fc_eff, len_eff;
    logic                  op;
    logic [SLOT_W-1:0]     slot;
    logic [FRAME_W-1:0]    frm;
    logic [DUR_W-1:0]      dur;
    logic [CFG_DATA_W-1:0] fc_val, len_val;

    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = OP_TICK;
    entry_slot     = '0;
    entry_frame    = '0;
    entry_duration = '0;
    cfg_write      = 1'b0;
    cfg_index      = REG_FRAME_COUNT;
    cfg_data       = '0;
    calm           = 1'b0;
    squeeze        = 1'b0;
    items_sent     = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // single frame after reset: ticks change nothing; load range checks
    send_item(OP_TICK, '0, '0, '0);
    send_item(OP_LOAD, 10'd0, 12'd0, 20'd1);
    send_item(OP_LOAD, 10'd1, 12'd1, 20'd1);
    send_item(OP_LOAD, 10'd2, 12'd0, 20'd0);
    send_item(OP_LOAD, 10'd3, 12'd0, 20'd1000001);
    send_item(OP_LOAD, 10'd1023, 12'd0, 20'd1000000);
    send_item(OP_LOAD, 10'd4, 12'd0, 20'hFFFFF);

    // frame count zero behaves as one
    write_reg(REG_FRAME_COUNT, 13'd0);
    send_item(OP_TICK, '0, '0, '0);

    // frame count above the strip maximum is capped
    write_reg(REG_FRAME_COUNT, 13'h1FFF);
    send_item(OP_LOAD, 10'd5, 12'hFFF, 20'd1);
    repeat (3) send_item(OP_TICK, '0, '0, '0);

    // plain cycling wraps at the frame count
    write_reg(REG_FRAME_COUNT, 13'd3);
    repeat (4) send_item(OP_TICK, '0, '0, '0);

    // short schedule, with a repeated frame that is not reported
    send_item(OP_LOAD, 10'd0, 12'd1, 20'd1);
    send_item(OP_LOAD, 10'd1, 12'd2, 20'd1);
    send_item(OP_LOAD, 10'd2, 12'd2, 20'd2);
    write_reg(REG_SCHEDULE_LENGTH, 13'd3);
    repeat (4) send_item(OP_TICK, '0, '0, '0);

    // shrink the strip so a stored frame goes stale
    write_reg(REG_FRAME_COUNT, 13'd2);
    repeat (2) send_item(OP_TICK, '0, '0, '0);

    // fill the whole table so any schedule length is safe to run
    write_reg(REG_SCHEDULE_LENGTH, 13'd0);
    write_reg(REG_FRAME_COUNT, 13'd4096);
    for (k = 0; k < MAX_ENTRIES; k++) begin
      send_item(OP_LOAD, SLOT_W'(k), FRAME_W'($urandom_range(4095)),
                DUR_W'($urandom_range(1, 3)));
    end

    // random phases, each under a fresh register setting
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      case ($urandom_range(6))
        0:       fc_val = 13'd0;
        1:       fc_val = 13'd1;
        2:       fc_val = 13'd4096;
        3:       fc_val = 13'h1FFF;
        4:       fc_val = CFG_DATA_W'($urandom_range(8191));
        default: fc_val = CFG_DATA_W'($urandom_range(2, 20));
      endcase
      case ($urandom_range(6))
        0:       len_val = 13'd0;
        1:       len_val = 13'd1;
        2:       len_val = 13'd1024;
        3:       len_val = 13'h7FF;
        4:       len_val = CFG_DATA_W'($urandom_range(8191));
        default: len_val = CFG_DATA_W'($urandom_range(2, 12));
      endcase
      if ($urandom_range(1)) begin
        write_reg(REG_FRAME_COUNT, fc_val);
        write_reg(REG_SCHEDULE_LENGTH, len_val);
      end else begin
        write_reg(REG_SCHEDULE_LENGTH, len_val);
        write_reg(REG_FRAME_COUNT, fc_val);
      end
      fc_eff  = sb.frames_in_use();
      len_eff = sb.length_in_use();
      calm = (phase == 5);
      if (phase == 3) squeeze = 1'b1;
      n = calm ? 200 : $urandom_range(20, 80);

      for (k = 0; k < n; k++) begin
        op   = ($urandom_range(99) < 30) ? OP_LOAD : OP_TICK;
        slot = '0;
        frm  = '0;
        dur  = '0;
        if (op == OP_LOAD) begin
          // mostly slots in use, mostly frames and durations that pass
          if (len_eff > 0 && $urandom_range(99) < 70) slot = SLOT_W'($urandom_range(len_eff - 1));
          else slot = SLOT_W'($urandom_range(1023));
          if ($urandom_range(99) < 60) frm = FRAME_W'($urandom_range(fc_eff - 1));
          else frm = FRAME_W'($urandom_range(4095));
          r = $urandom_range(99);
          if (r < 85) begin
            dur = DUR_W'($urandom_range(1, 4));
          end else if (r < 92) begin
            dur = DUR_W'($urandom_range(20'hFFFFF));
          end else begin
            case ($urandom_range(3))
              0:       dur = 20'd0;
              1:       dur = 20'd1000000;
              2:       dur = 20'd1000001;
              default: dur = 20'hFFFFF;
            endcase
          end
        end else begin
          slot = SLOT_W'($urandom_range(1023));
          frm  = FRAME_W'($urandom_range(4095));
          dur  = DUR_W'($urandom_range(20'hFFFFF));
        end
        send_item(op, slot, frm, dur);
      end
      calm = 1'b0;
    end

    // drain and let the block settle
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_ram.sv
hw/rtl/timed_frame_sequencer_top.sv
hw/rtl/tsq_checker.sv
tb/timed_frame_sequencer_top_test.sv
